// File: design/assert_macros.svh
// assertion macros used by the tokenizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational invariant, checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/cct_pkg.sv
// shared types and constants of the character class tokenizer
package cct_pkg;

  localparam int LINE_BITS_DEFAULT = 16;
  localparam int OUT_LINE_BITS     = 16;
  localparam int CFG_DATA_BITS     = 64;
  localparam int CFG_INDEX_BITS    = 3;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] NEWLINE   = 8'h0A;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_QUOTE_CHARS     = 3'd0,
    REG_QUOTE_COUNT     = 3'd1,
    REG_SPACE_CHARS     = 3'd2,
    REG_SPACE_COUNT     = 3'd3,
    REG_SEPARATOR_CHARS = 3'd4,
    REG_SEPARATOR_COUNT = 3'd5,
    REG_PUNCT_CHARS     = 3'd6,
    REG_PUNCT_COUNT     = 3'd7
  } reg_idx_t;

  localparam logic [31:0] QUOTE_CHARS_RST     = 32'h0000_2722;
  localparam logic [2:0]  QUOTE_COUNT_RST     = 3'd2;
  localparam logic [31:0] SPACE_CHARS_RST     = 32'h0A0D_0920;
  localparam logic [2:0]  SPACE_COUNT_RST     = 3'd4;
  localparam logic [31:0] SEPARATOR_CHARS_RST = 32'h0000_003B;
  localparam logic [2:0]  SEPARATOR_COUNT_RST = 3'd1;
  localparam logic [63:0] PUNCT_CHARS_RST     = 64'h0000_0000_3D2C_2928;
  localparam logic [3:0]  PUNCT_COUNT_RST     = 4'd4;

  typedef struct packed {
    logic [31:0] quote_chars;
    logic [2:0]  quote_count;
    logic [31:0] space_chars;
    logic [2:0]  space_count;
    logic [31:0] separator_chars;
    logic [2:0]  separator_count;
    logic [63:0] punct_chars;
    logic [3:0]  punct_count;
  } cfg_t;

  typedef struct packed {
    logic is_quote;
    logic is_separator;
    logic is_space;
    logic is_punct;
  } cls_t;

endpackage

// File: design/cct_classify.sv
// set membership of one byte against the configured character classes
module cct_classify (
  input  logic [7:0]    ch,
  input  cct_pkg::cfg_t cfg,
  output cct_pkg::cls_t cls
);

  // a count above the slot number enables every slot
  always_comb begin
    cls = '0;
    for (int i = 0; i < 4; i++) begin
      if (4'(i) < {1'b0, cfg.quote_count} && cfg.quote_chars[8*i +: 8] == ch)
        cls.is_quote = 1'b1;
      if (4'(i) < {1'b0, cfg.separator_count} && cfg.separator_chars[8*i +: 8] == ch)
        cls.is_separator = 1'b1;
      if (4'(i) < {1'b0, cfg.space_count} && cfg.space_chars[8*i +: 8] == ch)
        cls.is_space = 1'b1;
    end
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < cfg.punct_count && cfg.punct_chars[8*j +: 8] == ch)
        cls.is_punct = 1'b1;
    end
  end

endmodule

// File: design/char_class_tokenizer.sv
// character class tokenizer top level: input stage, classify and state update, result stage
// stages: input register, then result register; throughput: one word per cycle while
// out_stall is low; the tokenizer state updates as a word moves to the result register,
// so back-to-back words see the state left by the one before
// reset (rst, synchronous): both stages empty, tokenizer state cleared, line counters to 1,
// character class registers to their default sets
module char_class_tokenizer #(
  parameter int LINE_BITS = cct_pkg::LINE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [cct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input word channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         ch,
  input  logic                               last,
  // result word channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         ch_out,
  output logic                               keep,
  output logic                               close_before,
  output logic                               close_after,
  output logic                               stmt_done,
  output logic [cct_pkg::OUT_LINE_BITS-1:0]  stmt_start_line,
  output logic [cct_pkg::OUT_LINE_BITS-1:0]  line_now
);

  `include "assert_macros.svh"

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  // configuration registers
  cct_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quote_chars     <= cct_pkg::QUOTE_CHARS_RST;
      cfg.quote_count     <= cct_pkg::QUOTE_COUNT_RST;
      cfg.space_chars     <= cct_pkg::SPACE_CHARS_RST;
      cfg.space_count     <= cct_pkg::SPACE_COUNT_RST;
      cfg.separator_chars <= cct_pkg::SEPARATOR_CHARS_RST;
      cfg.separator_count <= cct_pkg::SEPARATOR_COUNT_RST;
      cfg.punct_chars     <= cct_pkg::PUNCT_CHARS_RST;
      cfg.punct_count     <= cct_pkg::PUNCT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cct_pkg::REG_QUOTE_CHARS:     cfg.quote_chars     <= cfg_data[31:0];
        cct_pkg::REG_QUOTE_COUNT:     cfg.quote_count     <= cfg_data[2:0];
        cct_pkg::REG_SPACE_CHARS:     cfg.space_chars     <= cfg_data[31:0];
        cct_pkg::REG_SPACE_COUNT:     cfg.space_count     <= cfg_data[2:0];
        cct_pkg::REG_SEPARATOR_CHARS: cfg.separator_chars <= cfg_data[31:0];
        cct_pkg::REG_SEPARATOR_COUNT: cfg.separator_count <= cfg_data[2:0];
        cct_pkg::REG_PUNCT_CHARS:     cfg.punct_chars     <= cfg_data;
        cct_pkg::REG_PUNCT_COUNT:     cfg.punct_count     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_last;
  logic       advance;   // input stage may hand its word to the result stage
  logic       fire;      // a word is processed this cycle

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // an empty input stage takes a word even while the result stage is held
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_ch   <= ch;
      s1_last <= last;
    end
  end

  // tokenizer state
  logic                 in_quote;
  logic [7:0]           open_quote;
  logic [7:0]           prev_byte;
  logic                 token_open;
  logic                 stmt_has_tokens;
  logic [LINE_BITS-1:0] line_counter;
  logic [LINE_BITS-1:0] stmt_line;

  logic                 in_quote_next;
  logic [7:0]           open_quote_next;
  logic [7:0]           prev_byte_next;
  logic                 token_open_next;
  logic                 stmt_has_tokens_next;
  logic [LINE_BITS-1:0] line_counter_next;
  logic [LINE_BITS-1:0] stmt_line_next;

  cct_pkg::cls_t cls;

  cct_classify u_classify (
    .ch  (s1_ch),
    .cfg (cfg),
    .cls (cls)
  );

  // per-word decision
  logic                 r_keep;
  logic                 r_cb;
  logic                 r_ca;
  logic                 r_done;
  logic [LINE_BITS-1:0] r_start;
  logic [LINE_BITS-1:0] line_bumped;
  logic                 quote_hit;

  always_comb begin
    // newline counts before classification, saturating
    line_bumped = line_counter;
    if (s1_ch == cct_pkg::NEWLINE && line_counter != LINE_MAX)
      line_bumped = line_counter + LINE_ONE;

    // a quote right after a backslash is escaped
    quote_hit = cls.is_quote && (prev_byte != cct_pkg::BACKSLASH);

    in_quote_next        = in_quote;
    open_quote_next      = open_quote;
    token_open_next      = token_open;
    stmt_has_tokens_next = stmt_has_tokens;
    stmt_line_next       = stmt_line;
    line_counter_next    = line_bumped;
    prev_byte_next       = s1_ch;
    r_keep  = 1'b0;
    r_cb    = 1'b0;
    r_ca    = 1'b0;
    r_done  = 1'b0;
    r_start = stmt_line;

    if (quote_hit && in_quote && open_quote == s1_ch) begin
      // closing quote ends the string token
      in_quote_next        = 1'b0;
      r_keep               = 1'b1;
      r_ca                 = 1'b1;
      token_open_next      = 1'b0;
      stmt_has_tokens_next = 1'b1;
    end else if (quote_hit && !in_quote) begin
      // opening quote closes any pending plain token first
      if (token_open) begin
        r_cb                 = 1'b1;
        stmt_has_tokens_next = 1'b1;
      end
      in_quote_next   = 1'b1;
      open_quote_next = s1_ch;
      r_keep          = 1'b1;
      token_open_next = 1'b1;
    end else if (in_quote) begin
      // any other byte inside a string, including a different quote
      r_keep          = 1'b1;
      token_open_next = 1'b1;
    end else if (cls.is_separator) begin
      if (token_open) begin
        r_cb            = 1'b1;
        token_open_next = 1'b0;
      end
      if (token_open || stmt_has_tokens) begin
        r_done  = 1'b1;
        r_start = stmt_line;
      end
      stmt_has_tokens_next = 1'b0;
      // next statement starts here, even after an empty one
      stmt_line_next       = line_bumped;
    end else if (cls.is_space) begin
      if (token_open) begin
        r_cb                 = 1'b1;
        token_open_next      = 1'b0;
        stmt_has_tokens_next = 1'b1;
      end
    end else if (cls.is_punct) begin
      // delimiter is a token of its own
      r_cb                 = token_open;
      r_keep               = 1'b1;
      r_ca                 = 1'b1;
      token_open_next      = 1'b0;
      stmt_has_tokens_next = 1'b1;
    end else begin
      r_keep          = 1'b1;
      token_open_next = 1'b1;
    end

    // final byte flushes the token and the statement, then starts a new source
    if (s1_last) begin
      if (token_open_next) begin
        r_ca                 = 1'b1;
        stmt_has_tokens_next = 1'b1;
      end
      if (stmt_has_tokens_next) begin
        r_done  = 1'b1;
        r_start = stmt_line_next;
      end
      in_quote_next        = 1'b0;
      open_quote_next      = '0;
      prev_byte_next       = '0;
      token_open_next      = 1'b0;
      stmt_has_tokens_next = 1'b0;
      line_counter_next    = LINE_ONE;
      stmt_line_next       = LINE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote        <= 1'b0;
      open_quote      <= '0;
      prev_byte       <= '0;
      token_open      <= 1'b0;
      stmt_has_tokens <= 1'b0;
      line_counter    <= LINE_ONE;
      stmt_line       <= LINE_ONE;
    end else if (fire) begin
      in_quote        <= in_quote_next;
      open_quote      <= open_quote_next;
      prev_byte       <= prev_byte_next;
      token_open      <= token_open_next;
      stmt_has_tokens <= stmt_has_tokens_next;
      line_counter    <= line_counter_next;
      stmt_line       <= stmt_line_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ch_out          <= s1_ch;
      keep            <= r_keep;
      close_before    <= r_cb;
      close_after     <= r_ca;
      stmt_done       <= r_done;
      // line numbers reported in the low bits, zero-extended if narrower
      stmt_start_line <= cct_pkg::OUT_LINE_BITS'(r_start);
      line_now        <= cct_pkg::OUT_LINE_BITS'(line_bumped);
    end
  end

  // checks
  `ASSERT_ALWAYS(a_line_nonzero, clk, rst, line_counter != '0, "line counter reached zero")
  `ASSERT_IMPLIES(a_quote_token, clk, rst, in_quote, token_open, "open string without open token")
  `ASSERT_IMPLIES(a_close_kept, clk, rst, out_valid && close_after, keep, "close_after on a dropped byte")
  `ASSERT_IMPLIES(a_stall_full, clk, rst, in_stall, s1_valid, "input stalled with empty input stage")

endmodule

// File: verif/tb_top.sv
// testbench for the character class tokenizer: directed, extreme and random streams
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any word moving on either channel before the run is called hung;
  // the worst legal stretch is a short drain plus a config load, far below this
  localparam int QUIET_LIMIT = 2000;
  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  // mismatch lines printed before the rest are only counted
  localparam int MAX_PRINTS = 40;

  // what the block reports for one source byte
  typedef struct packed {
    logic [7:0]  ch;
    logic        keep;
    logic        close_before;
    logic        close_after;
    logic        stmt_done;
    logic [15:0] start_line;
    logic [15:0] line_after;
  } byte_marks_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [cct_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
  logic [cct_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [7:0]                          ch = '0;
  logic                                last = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [7:0]                          ch_out;
  logic                                keep;
  logic                                close_before;
  logic                                close_after;
  logic                                stmt_done;
  logic [cct_pkg::OUT_LINE_BITS-1:0]   stmt_start_line;
  logic [cct_pkg::OUT_LINE_BITS-1:0]   line_now;

  // idle percentages of the sender (valid low) and receiver (stall high)
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  byte_marks_t expected_marks [$];

  // predictor copy of the character class registers
  logic [31:0] quote_set, space_set, sep_set;
  logic [63:0] punct_set;
  logic [2:0]  quote_n, space_n, sep_n;
  logic [3:0]  punct_n;

  // predictor copy of the tokenizer state
  logic        in_str;
  logic [7:0]  open_q;
  logic [7:0]  prev_ch;
  logic        tok_open;
  logic        stmt_busy;
  logic [15:0] line_cnt;
  logic [15:0] stmt_ln;

  char_class_tokenizer dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .ch              (ch),
    .last            (last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .ch_out          (ch_out),
    .keep            (keep),
    .close_before    (close_before),
    .close_after     (close_after),
    .stmt_done       (stmt_done),
    .stmt_start_line (stmt_start_line),
    .line_now        (line_now)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // membership in a packed byte set, low byte first; counts above the cap act as the cap
  function automatic logic in_class(input logic [7:0] c, input logic [63:0] set_bytes,
                                    input int unsigned cnt, input int unsigned cap);
    int unsigned n;
    n = (cnt > cap) ? cap : cnt;
    for (int unsigned i = 0; i < n; i++) begin
      if (set_bytes[8*i +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // start of a new source: everything but the class registers
  function automatic void clear_stream();
    in_str    = 1'b0;
    open_q    = 8'h00;
    prev_ch   = 8'h00;
    tok_open  = 1'b0;
    stmt_busy = 1'b0;
    line_cnt  = 16'd1;
    stmt_ln   = 16'd1;
  endfunction

  function automatic void reset_classes();
    quote_set = cct_pkg::QUOTE_CHARS_RST;
    quote_n   = cct_pkg::QUOTE_COUNT_RST;
    space_set = cct_pkg::SPACE_CHARS_RST;
    space_n   = cct_pkg::SPACE_COUNT_RST;
    sep_set   = cct_pkg::SEPARATOR_CHARS_RST;
    sep_n     = cct_pkg::SEPARATOR_COUNT_RST;
    punct_set = cct_pkg::PUNCT_CHARS_RST;
    punct_n   = cct_pkg::PUNCT_COUNT_RST;
  endfunction

  function automatic void apply_reg(input cct_pkg::reg_idx_t idx, input logic [63:0] val);
    case (idx)
      cct_pkg::REG_QUOTE_CHARS:     quote_set = val[31:0];
      cct_pkg::REG_QUOTE_COUNT:     quote_n   = val[2:0];
      cct_pkg::REG_SPACE_CHARS:     space_set = val[31:0];
      cct_pkg::REG_SPACE_COUNT:     space_n   = val[2:0];
      cct_pkg::REG_SEPARATOR_CHARS: sep_set   = val[31:0];
      cct_pkg::REG_SEPARATOR_COUNT: sep_n     = val[2:0];
      cct_pkg::REG_PUNCT_CHARS:     punct_set = val;
      cct_pkg::REG_PUNCT_COUNT:     punct_n   = val[3:0];
      default: ;
    endcase
  endfunction

  // classify one byte in priority order and advance the tokenizer state
  function automatic byte_marks_t classify_byte(input logic [7:0] c, input logic l);
    byte_marks_t m;
    logic        handled;
    logic [15:0] start;
    m       = '0;
    m.ch    = c;
    start   = stmt_ln;
    handled = 1'b0;

    // newline counts before classification, whatever class it falls in
    if (c == cct_pkg::NEWLINE && line_cnt < LINE_MAX) line_cnt = line_cnt + 16'd1;

    // an unescaped quote byte opens or closes a string
    if (in_class(c, {32'h0, quote_set}, quote_n, 4) && prev_ch != cct_pkg::BACKSLASH) begin
      if (in_str && open_q == c) begin
        in_str        = 1'b0;
        m.keep        = 1'b1;
        m.close_after = 1'b1;
        tok_open      = 1'b0;
        stmt_busy     = 1'b1;
        handled       = 1'b1;
      end else if (!in_str) begin
        // opening a string closes the pending token first
        if (tok_open) begin
          m.close_before = 1'b1;
          stmt_busy      = 1'b1;
        end
        in_str   = 1'b1;
        open_q   = c;
        m.keep   = 1'b1;
        tok_open = 1'b1;
        handled  = 1'b1;
      end
    end

    if (!handled) begin
      if (in_str) begin
        // inside a string every byte is kept, other quotes included
        m.keep   = 1'b1;
        tok_open = 1'b1;
      end else if (in_class(c, {32'h0, sep_set}, sep_n, 4)) begin
        if (tok_open) begin
          m.close_before = 1'b1;
          tok_open       = 1'b0;
          stmt_busy      = 1'b1;
        end
        if (stmt_busy) begin
          m.stmt_done = 1'b1;
          start       = stmt_ln;
          stmt_busy   = 1'b0;
        end
        // even an empty statement moves the start line
        stmt_ln = line_cnt;
      end else if (in_class(c, {32'h0, space_set}, space_n, 4)) begin
        if (tok_open) begin
          m.close_before = 1'b1;
          tok_open       = 1'b0;
          stmt_busy      = 1'b1;
        end
      end else if (in_class(c, punct_set, punct_n, 8)) begin
        if (tok_open) m.close_before = 1'b1;
        m.keep        = 1'b1;
        m.close_after = 1'b1;
        tok_open      = 1'b0;
        stmt_busy     = 1'b1;
      end else begin
        m.keep   = 1'b1;
        tok_open = 1'b1;
      end
    end

    prev_ch      = c;
    m.line_after = line_cnt;

    // final byte flushes the token and statement, then the stream starts over
    if (l) begin
      if (tok_open) begin
        m.close_after = 1'b1;
        stmt_busy     = 1'b1;
      end
      if (stmt_busy) begin
        m.stmt_done = 1'b1;
        start       = stmt_ln;
      end
      clear_stream();
    end

    m.start_line = start;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input logic [7:0] c);
    if (got !== want)
      report_mismatch($sformatf("byte 0x%02h %s: got 0x%0h, expected 0x%0h",
                                c, name, got, want));
  endtask

  // result side: take a word whenever one is offered and not stalled, then pick the
  // stall for the next edge
  always @(posedge clk) begin
    byte_marks_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_marks.size() == 0) begin
          report_mismatch($sformatf("result word 0x%02h with nothing expected", ch_out));
        end else begin
          want = expected_marks.pop_front();
          check_field("ch_out", {8'h0, ch_out}, {8'h0, want.ch}, want.ch);
          check_field("keep", {15'h0, keep}, {15'h0, want.keep}, want.ch);
          check_field("close_before", {15'h0, close_before}, {15'h0, want.close_before},
                      want.ch);
          check_field("close_after", {15'h0, close_after}, {15'h0, want.close_after},
                      want.ch);
          check_field("stmt_done", {15'h0, stmt_done}, {15'h0, want.stmt_done}, want.ch);
          check_field("stmt_start_line", stmt_start_line, want.start_line, want.ch);
          check_field("line_now", line_now, want.line_after, want.ch);
        end
      end
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // watchdog: a run in which nothing moves for too long is hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one byte, holding it until accepted; valid stays high afterwards so the
  // next byte can follow back to back
  task automatic send_byte(input logic [7:0] c, input logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_marks.push_back(classify_byte(c, l));
  endtask

  // lower valid and let every outstanding word come back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_marks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes; load_classes lowers it
  task automatic write_reg(input cct_pkg::reg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic load_classes(input logic [31:0] qc, input logic [2:0] qn,
                              input logic [31:0] sc, input logic [2:0] sn,
                              input logic [31:0] rc, input logic [2:0] rn,
                              input logic [63:0] pc, input logic [3:0] pn);
    write_reg(cct_pkg::REG_QUOTE_CHARS, {32'h0, qc});
    write_reg(cct_pkg::REG_QUOTE_COUNT, {61'h0, qn});
    write_reg(cct_pkg::REG_SPACE_CHARS, {32'h0, sc});
    write_reg(cct_pkg::REG_SPACE_COUNT, {61'h0, sn});
    write_reg(cct_pkg::REG_SEPARATOR_CHARS, {32'h0, rc});
    write_reg(cct_pkg::REG_SEPARATOR_COUNT, {61'h0, rn});
    write_reg(cct_pkg::REG_PUNCT_CHARS, pc);
    write_reg(cct_pkg::REG_PUNCT_COUNT, {60'h0, pn});
    cfg_we <= 1'b0;
  endtask

  // mostly in range, sometimes empty, sometimes above the cap
  function automatic logic [3:0] rand_count(input int unsigned cap, input int unsigned top);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(top));
    return 4'($urandom_range(cap, 1));
  endfunction

  function automatic logic [7:0] pick_from(input logic [63:0] set_bytes,
                                           input int unsigned cnt, input int unsigned cap);
    int unsigned n;
    n = (cnt > cap) ? cap : cnt;
    if (n == 0) return 8'($urandom_range(255));
    return set_bytes[8*$urandom_range(n-1) +: 8];
  endfunction

  // byte mix weighted toward the configured classes so strings, statements and
  // escapes form often; the tail is raw noise
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 14) return pick_from({32'h0, quote_set}, quote_n, 4);
    if (r < 19) return cct_pkg::BACKSLASH;
    if (r < 26) return cct_pkg::NEWLINE;
    if (r < 36) return pick_from({32'h0, sep_set}, sep_n, 4);
    if (r < 48) return pick_from({32'h0, space_set}, space_n, 4);
    if (r < 60) return pick_from(punct_set, punct_n, 8);
    if (r < 88) return 8'($urandom_range(8'h7A, 8'h61));
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default classes: token close on space, quote after a token, separator and other
  // quote and escaped quote inside a string, delimiter after a token, empty statement,
  // extreme bytes, unterminated string at the final byte, escape outside a string
  task automatic test_directed_defaults();
    logic [7:0] src [24];
    src = '{"a", "b", " ", "x", "\"", ";", "'", cct_pkg::BACKSLASH, "\"", "\"",
            "y", "(", 8'hFF, cct_pkg::NEWLINE, ";", ";", 8'h00, "\"", "q",
            cct_pkg::NEWLINE, cct_pkg::BACKSLASH, "\"", "=", ","};
    in_idle_pct  = 26;
    out_idle_pct = 56;
    drain();
    foreach (src[i]) send_byte(src[i], (i == 19 || i == 23));
  endtask

  // class register extremes: all sets empty, then counts past the cap with
  // overlapping sets and backslash as a separator
  task automatic test_class_extremes();
    logic [7:0] src [10];
    in_idle_pct  = 56;
    out_idle_pct = 26;
    drain();
    load_classes(cct_pkg::QUOTE_CHARS_RST, 3'd0, cct_pkg::SPACE_CHARS_RST, 3'd0,
                 cct_pkg::SEPARATOR_CHARS_RST, 3'd0, cct_pkg::PUNCT_CHARS_RST, 4'd0);
    // nothing is classified, so every byte extends one token
    src = '{"\"", " ", ";", "(", cct_pkg::NEWLINE, 8'h00, 8'hFF, "'", "a", "b"};
    foreach (src[i]) send_byte(src[i], i == 9);
    drain();
    load_classes(32'hFFFF_FFFF, 3'd7, 32'h0000_0000, 3'd7,
                 32'h5C5C_5C5C, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    // escaped 0xff outside a string falls through to the delimiter set
    src = '{"a", 8'hFF, 8'h00, 8'hFF, "b", 8'h00, cct_pkg::BACKSLASH, 8'hFF,
            cct_pkg::NEWLINE, "c"};
    foreach (src[i]) send_byte(src[i], i == 9);
  endtask

  // three idling modes, each with its own random class registers
  task automatic test_random_traffic();
    int unsigned in_mode [3];
    int unsigned out_mode [3];
    in_mode  = '{26, 56, 0};
    out_mode = '{56, 26, 0};
    for (int p = 0; p < 3; p++) begin
      drain();
      load_classes($urandom, 3'(rand_count(4, 7)), $urandom, 3'(rand_count(4, 7)),
                   $urandom, 3'(rand_count(4, 7)), {$urandom, $urandom},
                   rand_count(8, 15));
      in_idle_pct  = in_mode[p];
      out_idle_pct = out_mode[p];
      repeat (135) send_byte(pick_byte(), $urandom_range(24) == 0);
    end
  endtask

  initial begin
    reset_classes();
    clear_stream();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_class_extremes();
    test_random_traffic();
    drain();

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
